### rtl/core/cascaded_biquad_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Cascaded biquad filter assertion macros
// Property wrappers shared by the checker, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_FILTER_TOP_ASSERT_SVH
`define CASCADED_BIQUAD_FILTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cbf_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter package
// Sizes, codes, control word layout and the microcode table of the sequencer.
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam int MAX_STAGES = 16;
	localparam int NUM_COEFS  = 5;
	localparam int STAGE_W    = $clog2(MAX_STAGES + 1);
	localparam int COEF_DEPTH = NUM_COEFS * MAX_STAGES;
	localparam int CADDR_W    = $clog2(COEF_DEPTH);
	localparam int HIST_DEPTH = MAX_STAGES + 1;
	localparam int HADDR_W    = $clog2(HIST_DEPTH);

	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 32;
	localparam int HIST_W     = 32;
	localparam int GAIN_W     = 24;
	localparam int ACTIVE_W   = 5;
	localparam int STAGE_IN_W = 4;
	localparam int CSEL_W     = 3;
	localparam int PROD_W     = 64;
	localparam int ACC_W      = 67;
	localparam int SEC_FRAC   = 28;
	localparam int OUT_FRAC   = 22;
	localparam int CFG_DATA_W = 24;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h400000;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_SAMPLE = 2'd0;
	localparam mode_t MODE_COEF   = 2'd1;
	localparam mode_t MODE_CLEAR  = 2'd2;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_ACTIVE_STAGES = 1'b0;
	localparam reg_idx_t REG_OUT_GAIN      = 1'b1;

	typedef logic [CSEL_W-1:0] csel_t;
	localparam csel_t COEF_A0 = 3'd0;
	localparam csel_t COEF_A1 = 3'd1;
	localparam csel_t COEF_A2 = 3'd2;
	localparam csel_t COEF_B1 = 3'd3;
	localparam csel_t COEF_B2 = 3'd4;

	typedef enum logic [2:0] {
		MA_SIG,
		MA_X1,
		MA_X2,
		MA_Y1,
		MA_Y2
	} mul_a_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_START,
		JC_DONE,
		JC_ALWAYS,
		JC_OUTFREE
	} jump_t;

	typedef logic [3:0] step_t;
	localparam step_t ST_IDLE = 4'd0;
	localparam step_t ST_INIT = 4'd1;
	localparam step_t ST_LDX  = 4'd2;
	localparam step_t ST_SEC0 = 4'd3;
	localparam step_t ST_SEC1 = 4'd4;
	localparam step_t ST_SEC2 = 4'd5;
	localparam step_t ST_SEC3 = 4'd6;
	localparam step_t ST_SEC4 = 4'd7;
	localparam step_t ST_SEC5 = 4'd8;
	localparam step_t ST_SEC6 = 4'd9;
	localparam step_t ST_SEC7 = 4'd10;
	localparam step_t ST_FIN0 = 4'd11;
	localparam step_t ST_FIN1 = 4'd12;
	localparam step_t ST_FIN2 = 4'd13;

	typedef struct packed {
		csel_t   csel;
		logic    hrd_next;
		logic    x_load;
		logic    y_load;
		mul_a_t  mul_a;
		logic    mul_gain;
		acc_op_t acc_op;
		logic    sec_end;
		logic    hist_wr;
		logic    out_load;
		jump_t   jump;
		step_t   target;
	} ctl_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic               clr_all;
		logic               clr_above;
		logic [STAGE_W-1:0] keep;
	} hist_clr_t;

	typedef struct packed {
		logic               we;
		logic [CADDR_W-1:0] addr;
		logic [COEF_W-1:0]  data;
	} coef_wr_t;

	function automatic logic [STAGE_W-1:0] eff_stages(logic [ACTIVE_W-1:0] active);
		logic [STAGE_W-1:0] n;
		if (int'(active) > MAX_STAGES) begin
			n = STAGE_W'(MAX_STAGES);
		end else begin
			n = STAGE_W'(active);
		end
		return n;
	endfunction

	function automatic ctl_t ucode(step_t s);
		ctl_t c;
		c        = '0;
		c.csel   = COEF_A0;
		c.mul_a  = MA_SIG;
		c.acc_op = ACC_HOLD;
		c.jump   = JC_NEXT;
		c.target = ST_IDLE;
		unique case (s)
			ST_IDLE: begin
				c.jump   = JC_START;
				c.target = ST_INIT;
			end
			ST_INIT: begin
				c.hrd_next = 1'b0;
			end
			ST_LDX: begin
				c.x_load = 1'b1;
			end
			ST_SEC0: begin
				c.hrd_next = 1'b1;
				c.csel     = COEF_A0;
				c.jump     = JC_DONE;
				c.target   = ST_FIN0;
			end
			ST_SEC1: begin
				c.y_load = 1'b1;
				c.csel   = COEF_A1;
				c.mul_a  = MA_SIG;
			end
			ST_SEC2: begin
				c.csel   = COEF_A2;
				c.mul_a  = MA_X1;
				c.acc_op = ACC_LOAD;
			end
			ST_SEC3: begin
				c.csel   = COEF_B1;
				c.mul_a  = MA_X2;
				c.acc_op = ACC_ADD;
			end
			ST_SEC4: begin
				c.csel   = COEF_B2;
				c.mul_a  = MA_Y1;
				c.acc_op = ACC_ADD;
			end
			ST_SEC5: begin
				c.mul_a  = MA_Y2;
				c.acc_op = ACC_SUB;
			end
			ST_SEC6: begin
				c.acc_op = ACC_SUB;
			end
			ST_SEC7: begin
				c.sec_end = 1'b1;
				c.jump    = JC_ALWAYS;
				c.target  = ST_SEC0;
			end
			ST_FIN0: begin
				c.hist_wr  = 1'b1;
				c.mul_a    = MA_SIG;
				c.mul_gain = 1'b1;
			end
			ST_FIN1: begin
				c.acc_op = ACC_LOAD;
			end
			ST_FIN2: begin
				c.out_load = 1'b1;
				c.jump     = JC_OUTFREE;
				c.target   = ST_IDLE;
			end
			default: begin
				c.jump   = JC_ALWAYS;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

### rtl/core/cbf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbf_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/cbf_sequencer.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter sequencer
// Step counter over the microcode table, with conditional jumps.
// ----------------------------------------------------------------------------
module cbf_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cbf_pkg::status_t status,
	output cbf_pkg::ctl_t    ctl,
	output logic             idle
);

	cbf_pkg::step_t step_q;
	cbf_pkg::step_t step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cbf_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl  = cbf_pkg::ucode(step_q);
		idle = (step_q == cbf_pkg::ST_IDLE);
		unique case (ctl.jump)
			cbf_pkg::JC_NEXT: begin
				step_d = cbf_pkg::step_t'(step_q + 1'b1);
			end
			cbf_pkg::JC_START: begin
				step_d = start ? ctl.target : step_q;
			end
			cbf_pkg::JC_DONE: begin
				step_d = status.done ? ctl.target : cbf_pkg::step_t'(step_q + 1'b1);
			end
			cbf_pkg::JC_ALWAYS: begin
				step_d = ctl.target;
			end
			cbf_pkg::JC_OUTFREE: begin
				step_d = status.out_free ? ctl.target : step_q;
			end
			default: begin
				step_d = cbf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/cbf_datapath.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter datapath
// Coefficient and history memories, shared multiplier, accumulator,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module cbf_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [cbf_pkg::SAMPLE_W-1:0]  sample,
	input  cbf_pkg::ctl_t                        ctl,
	input  logic        [cbf_pkg::STAGE_W-1:0]   n,
	input  logic        [cbf_pkg::GAIN_W-1:0]    gain,
	input  cbf_pkg::coef_wr_t                    coef_wr,
	input  cbf_pkg::hist_clr_t                   hist_clr,
	output cbf_pkg::status_t                     status,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [cbf_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                 out_clip
);

	localparam int ACC_W  = cbf_pkg::ACC_W;
	localparam int HIST_W = cbf_pkg::HIST_W;

	localparam logic signed [ACC_W-1:0] SEC_HALF = ACC_W'(1) << (cbf_pkg::SEC_FRAC - 1);
	localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (cbf_pkg::OUT_FRAC - 1);
	localparam logic signed [ACC_W-1:0] HIST_MAX = (ACC_W'(1) << (HIST_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] HIST_MIN = ~HIST_MAX;
	localparam logic signed [ACC_W-1:0] OUT_MAX  =
		(ACC_W'(1) << (cbf_pkg::SAMPLE_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] OUT_MIN  = ~OUT_MAX;

	logic signed [HIST_W-1:0]          sig_q;
	logic signed [HIST_W-1:0]          x1_q;
	logic signed [HIST_W-1:0]          x2_q;
	logic signed [HIST_W-1:0]          y1_q;
	logic signed [HIST_W-1:0]          y2_q;
	logic        [cbf_pkg::STAGE_W-1:0] k_q;
	logic        [cbf_pkg::CADDR_W-1:0] cbase_q;
	logic                              clip_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [cbf_pkg::PROD_W-1:0] prod_s1;
	logic                              cv_q;
	logic                              hv_q;
	logic                              cvalid_q [cbf_pkg::COEF_DEPTH];
	logic                              hvalid_q [cbf_pkg::HIST_DEPTH];

	logic        [cbf_pkg::CADDR_W-1:0] craddr;
	logic        [cbf_pkg::COEF_W-1:0]  crdata;
	logic        [cbf_pkg::HADDR_W-1:0] hraddr;
	logic        [cbf_pkg::HADDR_W-1:0] hwaddr;
	logic        [2*HIST_W-1:0]         hrdata;
	logic        [2*HIST_W-1:0]         hwdata;
	logic                               hwe;

	logic signed [cbf_pkg::COEF_W-1:0] coef_val;
	logic signed [HIST_W-1:0]          mul_a_val;
	logic signed [cbf_pkg::COEF_W-1:0] mul_b_val;
	logic signed [ACC_W-1:0]           prod_ext;
	logic signed [ACC_W-1:0]           sec_shift;
	logic signed [ACC_W-1:0]           out_shift;
	logic signed [HIST_W-1:0]          sec_y;
	logic                              sec_sat;
	logic        [cbf_pkg::SAMPLE_W-1:0] out_y;
	logic                              out_sat;

	assign craddr = cbase_q + cbf_pkg::CADDR_W'(ctl.csel);
	assign hraddr = ctl.hrd_next ? cbf_pkg::HADDR_W'(k_q + 1'b1) : cbf_pkg::HADDR_W'(k_q);
	assign hwaddr = cbf_pkg::HADDR_W'(k_q);
	assign hwe    = ctl.sec_end | ctl.hist_wr;
	assign hwdata = {x1_q, sig_q};

	cbf_ram #(
		.WIDTH(cbf_pkg::COEF_W),
		.DEPTH(cbf_pkg::COEF_DEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_wr.we),
		.waddr(coef_wr.addr),
		.wdata(coef_wr.data),
		.raddr(craddr),
		.rdata(crdata)
	);

	cbf_ram #(
		.WIDTH(2 * HIST_W),
		.DEPTH(cbf_pkg::HIST_DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (hwe),
		.waddr(hwaddr),
		.wdata(hwdata),
		.raddr(hraddr),
		.rdata(hrdata)
	);

	always_comb begin
		coef_val = cv_q ? $signed(crdata) : '0;
		unique case (ctl.mul_a)
			cbf_pkg::MA_SIG: mul_a_val = sig_q;
			cbf_pkg::MA_X1:  mul_a_val = x1_q;
			cbf_pkg::MA_X2:  mul_a_val = x2_q;
			cbf_pkg::MA_Y1:  mul_a_val = y1_q;
			cbf_pkg::MA_Y2:  mul_a_val = y2_q;
			default:         mul_a_val = sig_q;
		endcase
		mul_b_val = ctl.mul_gain ?
			$signed({{(cbf_pkg::COEF_W - cbf_pkg::GAIN_W){1'b0}}, gain}) : coef_val;
		prod_ext  = ACC_W'(prod_s1);
	end

	always_comb begin
		sec_shift = (acc_q + SEC_HALF) >>> cbf_pkg::SEC_FRAC;
		priority if (sec_shift > HIST_MAX) begin
			sec_y   = HIST_MAX[HIST_W-1:0];
			sec_sat = 1'b1;
		end else if (sec_shift < HIST_MIN) begin
			sec_y   = HIST_MIN[HIST_W-1:0];
			sec_sat = 1'b1;
		end else begin
			sec_y   = sec_shift[HIST_W-1:0];
			sec_sat = 1'b0;
		end
		out_shift = (acc_q + OUT_HALF) >>> cbf_pkg::OUT_FRAC;
		priority if (out_shift > OUT_MAX) begin
			out_y   = OUT_MAX[cbf_pkg::SAMPLE_W-1:0];
			out_sat = 1'b1;
		end else if (out_shift < OUT_MIN) begin
			out_y   = OUT_MIN[cbf_pkg::SAMPLE_W-1:0];
			out_sat = 1'b1;
		end else begin
			out_y   = out_shift[cbf_pkg::SAMPLE_W-1:0];
			out_sat = 1'b0;
		end
	end

	assign status.done     = (k_q == n);
	assign status.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < cbf_pkg::COEF_DEPTH; j++) begin
				cvalid_q[j] <= 1'b0;
			end
			for (int j = 0; j < cbf_pkg::HIST_DEPTH; j++) begin
				hvalid_q[j] <= 1'b0;
			end
			cv_q <= 1'b0;
			hv_q <= 1'b0;
		end else begin
			for (int j = 0; j < cbf_pkg::COEF_DEPTH; j++) begin
				if (coef_wr.we && coef_wr.addr == cbf_pkg::CADDR_W'(j)) begin
					cvalid_q[j] <= 1'b1;
				end
			end
			for (int j = 0; j < cbf_pkg::HIST_DEPTH; j++) begin
				priority if (hist_clr.clr_all) begin
					hvalid_q[j] <= 1'b0;
				end else if (hist_clr.clr_above && j > int'(hist_clr.keep)) begin
					hvalid_q[j] <= 1'b0;
				end else if (hwe && hwaddr == cbf_pkg::HADDR_W'(j)) begin
					hvalid_q[j] <= 1'b1;
				end else begin
					hvalid_q[j] <= hvalid_q[j];
				end
			end
			cv_q <= (int'(craddr) < cbf_pkg::COEF_DEPTH) && cvalid_q[craddr];
			hv_q <= (int'(hraddr) < cbf_pkg::HIST_DEPTH) && hvalid_q[hraddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			cbase_q   <= '0;
			clip_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (start) begin
				k_q     <= '0;
				cbase_q <= '0;
				clip_q  <= 1'b0;
			end else if (ctl.sec_end) begin
				k_q     <= cbf_pkg::STAGE_W'(k_q + 1'b1);
				cbase_q <= cbase_q + cbf_pkg::CADDR_W'(cbf_pkg::NUM_COEFS);
				clip_q  <= clip_q | sec_sat;
			end
			if (ctl.out_load && status.out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a_val * mul_b_val;
		unique case (ctl.acc_op)
			cbf_pkg::ACC_HOLD: acc_q <= acc_q;
			cbf_pkg::ACC_LOAD: acc_q <= prod_ext;
			cbf_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			cbf_pkg::ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:           acc_q <= acc_q;
		endcase
		if (start) begin
			sig_q <= HIST_W'(sample);
		end else if (ctl.sec_end) begin
			sig_q <= sec_y;
		end
		if (ctl.x_load) begin
			x1_q <= hv_q ? hrdata[HIST_W-1:0] : '0;
			x2_q <= hv_q ? hrdata[2*HIST_W-1:HIST_W] : '0;
		end else if (ctl.sec_end) begin
			x1_q <= y1_q;
			x2_q <= y2_q;
		end
		if (ctl.y_load) begin
			y1_q <= hv_q ? hrdata[HIST_W-1:0] : '0;
			y2_q <= hv_q ? hrdata[2*HIST_W-1:HIST_W] : '0;
		end
		if (ctl.out_load && status.out_free) begin
			out_sample <= out_y;
			out_clip   <= clip_q | out_sat;
		end
	end

endmodule

### rtl/core/cascaded_biquad_filter_top.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter, top level
// Stream front end, configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// A filter request runs the n active sections one after another through the
// single shared 32x32 multiplier, which forms the five products of one
// section in turn, with a rounding step per section and then the gain stage.
// A coefficient write, a history clear or an unused mode leaves the block
// idle and gives no result. The input side takes a new request as soon as
// the previous result sits in the output register. Reset needs no clearing
// pass: memory entries carry valid bits and read as zero until written.
module cascaded_biquad_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample_in [23:0], stage_index [27:24], coef_index [30:28], coef_value [62:31]
	input  logic [63:0]                         s_tdata,
	// mode [1:0]
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// sample_out [23:0]
	output logic [cbf_pkg::SAMPLE_W-1:0]        m_tdata,
	// clipped [0]
	output logic [0:0]                          m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  cbf_pkg::reg_idx_t                   cfg_index,
	input  logic [cbf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [cbf_pkg::ACTIVE_W-1:0] active_q;
	logic [cbf_pkg::GAIN_W-1:0]   gain_q;

	logic                         accept;
	logic                         cfg_we;
	logic                         start;
	logic                         idle;
	cbf_pkg::mode_t               mode;
	logic [cbf_pkg::STAGE_IN_W-1:0] stage_in;
	cbf_pkg::csel_t               coef_idx;
	cbf_pkg::ctl_t                ctl;
	cbf_pkg::status_t             status;
	cbf_pkg::coef_wr_t            coef_wr;
	cbf_pkg::hist_clr_t           hist_clr;
	logic                         out_clip;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign s_tready  = idle;
	assign accept    = s_tvalid && s_tready;
	assign mode      = s_tuser;
	assign stage_in  = s_tdata[27:24];
	assign coef_idx  = s_tdata[30:28];
	assign start     = accept && (mode == cbf_pkg::MODE_SAMPLE);

	always_comb begin
		coef_wr.we   = accept && (mode == cbf_pkg::MODE_COEF) &&
			(int'(stage_in) < cbf_pkg::MAX_STAGES) && (int'(coef_idx) < cbf_pkg::NUM_COEFS);
		coef_wr.addr = cbf_pkg::CADDR_W'(int'(stage_in) * cbf_pkg::NUM_COEFS + int'(coef_idx));
		coef_wr.data = s_tdata[62:31];
		hist_clr.clr_all   = accept && (mode == cbf_pkg::MODE_CLEAR);
		hist_clr.clr_above = cfg_we && (cfg_index == cbf_pkg::REG_ACTIVE_STAGES);
		hist_clr.keep      = cbf_pkg::eff_stages(cfg_data[cbf_pkg::ACTIVE_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			gain_q   <= cbf_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbf_pkg::REG_ACTIVE_STAGES: active_q <= cfg_data[cbf_pkg::ACTIVE_W-1:0];
				cbf_pkg::REG_OUT_GAIN:      gain_q   <= cfg_data[cbf_pkg::GAIN_W-1:0];
				default:                    gain_q   <= gain_q;
			endcase
		end
	end

	cbf_sequencer u_sequencer (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.ctl   (ctl),
		.idle  (idle)
	);

	cbf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    ($signed(s_tdata[cbf_pkg::SAMPLE_W-1:0])),
		.ctl       (ctl),
		.n         (cbf_pkg::eff_stages(active_q)),
		.gain      (gain_q),
		.coef_wr   (coef_wr),
		.hist_clr  (hist_clr),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_sample(m_tdata),
		.out_clip  (out_clip)
	);

	assign m_tuser = out_clip;

endmodule

### rtl/core/cbf_checker.sv
// ----------------------------------------------------------------------------
// Cascaded biquad filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_filter_top_assert.svh"

module cbf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [1:0]                     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cbf_pkg::SAMPLE_W-1:0]   m_tdata,
	input logic [0:0]                     m_tuser
);

	// A stalled result keeps its value until it is taken.
	`CBF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// A filter request occupies the block for the following cycles.
	`CBF_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && s_tuser == cbf_pkg::MODE_SAMPLE, !s_tready, "ready stayed high after a filter request")

	// Coefficient writes, clears and unused modes finish at once.
	`CBF_ASSERT_NEXT(a_ctrl_quick, s_tvalid && s_tready && s_tuser != cbf_pkg::MODE_SAMPLE, s_tready, "ready dropped after a control request")

	// A new result only appears at the end of a busy period.
	`CBF_ASSERT_SAME(a_result_after_busy, $rose(m_tvalid), !$past(s_tready), "result appeared without a filter request in progress")

endmodule

bind cascaded_biquad_filter_top cbf_checker u_cbf_checker (.*);

### bench/tb_cascaded_biquad_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded biquad filter testbench
// Sends filter, coefficient and clear requests with random gaps and random
// output back-pressure. Each filter result is checked bit for bit against a
// fixed-point model of the section cascade and the output gain.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_filter_top;

	localparam cbf_pkg::mode_t MODE_UNUSED     = 2'd3;
	localparam cbf_pkg::csel_t COEF_NONE       = 3'd7;
	localparam int             SETTLE_CYCLES   = 150;
	localparam int             RANDOM_REQUESTS = 1080;
	localparam logic [31:0]    COEF_ONE        = 32'h1000_0000;

	typedef struct packed {
		logic [cbf_pkg::SAMPLE_W-1:0] out_sample;
		logic                         clipped;
	} audio_out_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [63:0]                    s_tdata   = '0;
	logic [1:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [cbf_pkg::SAMPLE_W-1:0]   m_tdata;
	logic [0:0]                     m_tuser;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	cbf_pkg::reg_idx_t              cfg_index = cbf_pkg::REG_ACTIVE_STAGES;
	logic [cbf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	int                             coef_mem [cbf_pkg::NUM_COEFS*cbf_pkg::MAX_STAGES];
	int                             hist_d1 [cbf_pkg::MAX_STAGES+1];
	int                             hist_d2 [cbf_pkg::MAX_STAGES+1];
	logic [cbf_pkg::ACTIVE_W-1:0]   active_cnt = '0;
	logic [cbf_pkg::GAIN_W-1:0]     gain_q22   = cbf_pkg::GAIN_RESET;

	audio_out_t                     expected_audio_q [$];
	int                             requests_sent = 0;
	int                             mismatches    = 0;
	bit                             burst         = 1'b0;
	int                             stall_left    = 0;
	int                             calm_left     = 0;

	cascaded_biquad_filter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int stages_in_use();
		return (int'(active_cnt) > cbf_pkg::MAX_STAGES) ? cbf_pkg::MAX_STAGES :
			int'(active_cnt);
	endfunction

	function automatic void clear_history(int from);
		for (int k = from; k <= cbf_pkg::MAX_STAGES; k++) begin
			hist_d1[k] = 0;
			hist_d2[k] = 0;
		end
	endfunction

	function automatic logic signed [69:0] coef_product(int c, int h);
		return 70'(longint'(c) * longint'(h));
	endfunction

	// Runs one sample through the active sections and the gain stage, and
	// advances the delay lines the way the hardware does.
	function automatic audio_out_t filter_sample(logic signed [cbf_pkg::SAMPLE_W-1:0] x_in);
		audio_out_t         r;
		logic signed [69:0] acc;
		int                 sig;
		int                 y;
		int                 n;
		int                 base;
		longint             scaled;
		logic               clip;
		clip = 1'b0;
		n    = stages_in_use();
		sig  = int'(x_in);
		for (int k = 0; k < n; k++) begin
			base = cbf_pkg::NUM_COEFS * k;
			acc  = coef_product(coef_mem[base + cbf_pkg::COEF_A0], sig);
			acc  = acc + coef_product(coef_mem[base + cbf_pkg::COEF_A1], hist_d1[k]);
			acc  = acc + coef_product(coef_mem[base + cbf_pkg::COEF_A2], hist_d2[k]);
			acc  = acc - coef_product(coef_mem[base + cbf_pkg::COEF_B1], hist_d1[k+1]);
			acc  = acc - coef_product(coef_mem[base + cbf_pkg::COEF_B2], hist_d2[k+1]);
			acc  = (acc + 70'sd134217728) >>> cbf_pkg::SEC_FRAC;
			if (acc > 70'sd2147483647) begin
				y    = 32'h7FFF_FFFF;
				clip = 1'b1;
			end else if (acc < -70'sd2147483648) begin
				y    = 32'h8000_0000;
				clip = 1'b1;
			end else begin
				y = int'(acc[31:0]);
			end
			hist_d2[k] = hist_d1[k];
			hist_d1[k] = sig;
			sig        = y;
		end
		hist_d2[n] = hist_d1[n];
		hist_d1[n] = sig;

		scaled = longint'(sig) * longint'(gain_q22);
		scaled = (scaled + 64'sd2097152) >>> cbf_pkg::OUT_FRAC;
		if (scaled > 64'sd8388607) begin
			scaled = 64'sd8388607;
			clip   = 1'b1;
		end else if (scaled < -64'sd8388608) begin
			scaled = -64'sd8388608;
			clip   = 1'b1;
		end
		r.out_sample = scaled[cbf_pkg::SAMPLE_W-1:0];
		r.clipped    = clip;
		return r;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end
		if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic int rand_signed(int mag);
		return int'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	function automatic logic [31:0] coef_value(cbf_pkg::csel_t ci, bit wild);
		if (wild) begin
			return $urandom();
		end
		return (ci < cbf_pkg::COEF_B1) ? rand_signed(1 << 28) : rand_signed(1 << 27);
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 100) begin
			$display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
		end
		mismatches++;
	endtask

	task automatic send_item(input cbf_pkg::mode_t md,
			input logic [cbf_pkg::SAMPLE_W-1:0] smp,
			input logic [cbf_pkg::STAGE_IN_W-1:0] st, input cbf_pkg::csel_t ci,
			input logic [31:0] cv);
		int gap;
		gap = (burst || $urandom_range(0, 1)) ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, cv, ci, st, smp};
		s_tuser  <= md;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (md)
			cbf_pkg::MODE_SAMPLE: begin
				expected_audio_q.push_back(filter_sample(smp));
			end
			cbf_pkg::MODE_COEF: begin
				if (int'(st) < cbf_pkg::MAX_STAGES && ci < cbf_pkg::NUM_COEFS) begin
					coef_mem[cbf_pkg::NUM_COEFS * st + ci] = int'(cv);
				end
			end
			cbf_pkg::MODE_CLEAR: begin
				clear_history(0);
			end
			default: begin
			end
		endcase
		if (md != MODE_UNUSED && !(md == cbf_pkg::MODE_COEF && ci >= cbf_pkg::NUM_COEFS)) begin
			requests_sent++;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_audio_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cbf_pkg::reg_idx_t idx,
			input logic [cbf_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == cbf_pkg::REG_ACTIVE_STAGES) begin
			active_cnt = val[cbf_pkg::ACTIVE_W-1:0];
			clear_history(stages_in_use() + 1);
		end else begin
			gain_q22 = val[cbf_pkg::GAIN_W-1:0];
		end
		@(posedge clk);
	endtask

	// Registers change only once the block has gone quiet, including after
	// requests that produce no result.
	task automatic set_config(input logic [cbf_pkg::ACTIVE_W-1:0] stages,
			input logic [cbf_pkg::GAIN_W-1:0] gain);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(cbf_pkg::REG_ACTIVE_STAGES, cbf_pkg::CFG_DATA_W'(stages));
		write_reg(cbf_pkg::REG_OUT_GAIN, gain);
	endtask

	task automatic test_bypass();
		send_item(cbf_pkg::MODE_SAMPLE, 24'h7FFFFF, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h800000, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h000000, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		send_item(cbf_pkg::MODE_SAMPLE, 24'hFFFFFF, 4'd0, cbf_pkg::COEF_A0, 32'h0);
	endtask

	task automatic test_coef_writes();
		send_item(cbf_pkg::MODE_COEF, 24'hFFFFFF, 4'd0, cbf_pkg::COEF_A0, COEF_ONE);
		send_item(cbf_pkg::MODE_COEF, 24'h000000, 4'd15, cbf_pkg::COEF_B2, 32'h8000_0000);
		send_item(cbf_pkg::MODE_COEF, 24'h5A5A5A, 4'd15, COEF_NONE, 32'hFFFF_FFFF);
		send_item(MODE_UNUSED, 24'h7FFFFF, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		send_item(cbf_pkg::MODE_CLEAR, 24'h000000, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		set_config(5'd1, cbf_pkg::GAIN_RESET);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h400000, 4'd0, cbf_pkg::COEF_A0, 32'h0);
	endtask

	task automatic test_saturation();
		set_config(5'd1, 24'hFFFFFF);
		send_item(cbf_pkg::MODE_COEF, 24'h0, 4'd0, cbf_pkg::COEF_A0, 32'h7FFF_FFFF);
		send_item(cbf_pkg::MODE_COEF, 24'h0, 4'd0, cbf_pkg::COEF_B1, 32'h8000_0000);
		repeat (3) send_item(cbf_pkg::MODE_SAMPLE, 24'h7FFFFF, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h800000, 4'd0, cbf_pkg::COEF_A0, 32'h0);
	endtask

	task automatic test_stage_count();
		set_config(5'd31, 24'h0);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h7FFFFF, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		set_config(5'd16, cbf_pkg::GAIN_RESET);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h123456, 4'd0, cbf_pkg::COEF_A0, 32'h0);
		set_config(5'd0, cbf_pkg::GAIN_RESET);
		set_config(5'd1, cbf_pkg::GAIN_RESET);
		send_item(cbf_pkg::MODE_SAMPLE, 24'h2ABCDE, 4'd0, cbf_pkg::COEF_A0, 32'h0);
	endtask

	// Each phase picks a setting, programs the active sections and then runs
	// a stream that is mostly samples with some clears and stray writes.
	task automatic test_random_traffic();
		int                           start;
		int                           pick;
		int                           stages;
		int                           body;
		bit                           wild;
		logic [cbf_pkg::GAIN_W-1:0]   gain;
		logic [cbf_pkg::SAMPLE_W-1:0] smp;
		start = requests_sent;
		while (requests_sent - start < RANDOM_REQUESTS) begin
			pick   = $urandom_range(0, 9);
			stages = (pick == 0) ? 0 : (pick == 1) ? cbf_pkg::MAX_STAGES :
				(pick == 2) ? $urandom_range(cbf_pkg::MAX_STAGES + 1, 31) :
				$urandom_range(1, 4);
			pick = $urandom_range(0, 9);
			gain = (pick == 0) ? 24'h0 : (pick == 1) ? 24'hFFFFFF :
				(pick < 5) ? cbf_pkg::GAIN_W'($urandom()) :
				cbf_pkg::GAIN_W'($urandom_range(24'h200000, 24'h600000));
			set_config(cbf_pkg::ACTIVE_W'(stages), gain);
			burst = ($urandom_range(0, 3) == 0);
			wild  = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1)) begin
				send_item(cbf_pkg::MODE_CLEAR, cbf_pkg::SAMPLE_W'($urandom()),
					cbf_pkg::STAGE_IN_W'($urandom()), cbf_pkg::csel_t'($urandom()),
					$urandom());
			end
			for (int k = 0; k < stages && k < cbf_pkg::MAX_STAGES; k++) begin
				for (int c = 0; c < cbf_pkg::NUM_COEFS; c++) begin
					send_item(cbf_pkg::MODE_COEF, cbf_pkg::SAMPLE_W'($urandom()),
						cbf_pkg::STAGE_IN_W'(k), cbf_pkg::csel_t'(c),
						coef_value(cbf_pkg::csel_t'(c), wild));
				end
			end
			body = $urandom_range(20, 60);
			for (int i = 0; i < body; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					pick = $urandom_range(0, 9);
					smp  = (pick < 6) ? cbf_pkg::SAMPLE_W'($urandom()) :
						(pick < 9) ? cbf_pkg::SAMPLE_W'(rand_signed(1 << 20)) :
						($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
					send_item(cbf_pkg::MODE_SAMPLE, smp, cbf_pkg::STAGE_IN_W'($urandom()),
						cbf_pkg::csel_t'($urandom()), $urandom());
				end else if (pick < 90) begin
					send_item(cbf_pkg::MODE_CLEAR, cbf_pkg::SAMPLE_W'($urandom()),
						cbf_pkg::STAGE_IN_W'($urandom()), cbf_pkg::csel_t'($urandom()),
						$urandom());
				end else if (pick < 94) begin
					send_item(cbf_pkg::MODE_COEF, cbf_pkg::SAMPLE_W'($urandom()),
						cbf_pkg::STAGE_IN_W'($urandom()),
						cbf_pkg::csel_t'($urandom_range(0, cbf_pkg::NUM_COEFS - 1)),
						coef_value(cbf_pkg::csel_t'($urandom_range(0, cbf_pkg::NUM_COEFS - 1)),
							wild));
				end else if (pick < 97) begin
					send_item(cbf_pkg::MODE_COEF, cbf_pkg::SAMPLE_W'($urandom()),
						cbf_pkg::STAGE_IN_W'($urandom()),
						cbf_pkg::csel_t'($urandom_range(cbf_pkg::NUM_COEFS, 7)), $urandom());
				end else begin
					send_item(MODE_UNUSED, cbf_pkg::SAMPLE_W'($urandom()),
						cbf_pkg::STAGE_IN_W'($urandom()), cbf_pkg::csel_t'($urandom()),
						$urandom());
				end
				if ($urandom_range(0, 199) == 0) begin
					wait_drained();
				end
			end
		end
		burst = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_back_pressure
		int r;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left = 0;
			calm_left  = 0;
		end else if (calm_left > 0) begin
			calm_left--;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				calm_left = 300;
				m_tready  <= 1'b1;
			end else if (r < 25) begin
				stall_left = idle_gap() - 1;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : score_results
		audio_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_audio_q.size() == 0) begin
				report_mismatch("result without a pending request", 32'(m_tdata), 32'h0);
			end else begin
				want = expected_audio_q.pop_front();
				if (m_tdata !== want.out_sample) begin
					report_mismatch("sample_out", 32'(m_tdata), 32'(want.out_sample));
				end
				if (m_tuser[0] !== want.clipped) begin
					report_mismatch("clipped", 32'(m_tuser), 32'(want.clipped));
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass();
		test_coef_writes();
		test_saturation();
		test_stage_count();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cbf_pkg.sv
rtl/core/cbf_ram.sv
rtl/core/cbf_sequencer.sv
rtl/core/cbf_datapath.sv
rtl/core/cascaded_biquad_filter_top.sv
rtl/core/cbf_checker.sv
bench/tb_cascaded_biquad_filter_top.sv
